### design/salc_pkg.sv
`timescale 1ns / 1ps
package salc_pkg;
  localparam int WAYS_DEF = 8;
  localparam int SETS_DEF = 1024;
  localparam int ADDR_W = 32;
  localparam int AGE_W = 3;
  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;
  localparam int OFS_W = 5;
  localparam int IDXB_W = 4;
  localparam int NW_W = 4;
  localparam int CNT_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INDEX_BITS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WAYS_IN_USE = 2'd2;
  localparam int OUT_W = 72;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_WRITE
  } bk_state_t;
endpackage

### design/salc_front.sv
`timescale 1ns / 1ps
// Splits the address into set index and tag under the current configuration.
module salc_front
  import salc_pkg::*;
#(
  parameter int SETS = SETS_DEF,
  parameter int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic [ADDR_W-1:0] address,
  input  logic [OFS_W-1:0]  offset_bits,
  input  logic [IDXB_W-1:0] index_bits,
  output logic [SET_W-1:0]  set_idx,
  output logic [ADDR_W-1:0] tag
);
  logic [ADDR_W-1:0] shifted;
  logic [ADDR_W-1:0] idx_mask;
  logic [ADDR_W-1:0] masked;
  logic [OFS_W:0]    split;

  // Index and tag fields; the tag is zero once the split covers the address.
  always_comb begin
    shifted  = address >> offset_bits;
    idx_mask = ~({ADDR_W{1'b1}} << index_bits);
    masked   = shifted & idx_mask;
    split    = {1'b0, offset_bits} + {{(OFS_W + 1 - IDXB_W){1'b0}}, index_bits};
    tag      = (split >= (OFS_W + 1)'(ADDR_W)) ? '0 : (address >> split);
    set_idx  = SET_W'(masked % SETS);
  end
endmodule

### design/salc_queue.sv
`timescale 1ns / 1ps
// Two-entry request queue between the front and the back.
module salc_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  logic [W-1:0] slots [2];
  logic         rd_ptr;
  logic         wr_ptr;
  logic [1:0]   fill;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = slots[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (out_valid && out_ready) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'((in_valid && in_ready) ? 1 : 0)
                   - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) slots[wr_ptr] <= in_data;
  end
endmodule

### design/salc_back.sv
`timescale 1ns / 1ps
// Read-modify-write of one set: tag memory, per-set valid and age rows,
// hit search, victim choice, aging and the result register.
module salc_back
  import salc_pkg::*;
#(
  parameter int WAYS = WAYS_DEF,
  parameter int SETS = SETS_DEF,
  parameter int SET_W = (SETS > 1) ? $clog2(SETS) : 1,
  parameter int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [SET_W-1:0]  req_set,
  input  logic [ADDR_W-1:0] req_tag,
  input  logic [NW_W-1:0]   ways_in_use,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [OUT_W-1:0]  res_data,
  output logic              clearing
);
  localparam int WC_W = $clog2(WAYS + 1);

  // Tag store: one row of all ways per set.
  logic [ADDR_W-1:0] tag_mem [SETS][WAYS];
  // Valid and age rows; cleared by a pass after reset.
  logic [WAYS-1:0]       val_mem [SETS];
  logic [AGE_W-1:0]      age_mem [SETS][WAYS];

  bk_state_t state, state_next;
  logic [SET_W:0]    clr_cnt;
  logic [SET_W-1:0]  cur_set;
  logic [ADDR_W-1:0] cur_tag;
  logic [ADDR_W-1:0] rd_tags [WAYS];
  logic [WAYS-1:0]   rd_val;
  logic [AGE_W-1:0]  rd_age [WAYS];
  logic [CNT_W-1:0]  hits_seen, misses_seen;
  logic              out_full;

  logic [WC_W-1:0]   nways;
  logic              hit, found_empty;
  logic [WAY_W-1:0]  chosen;
  logic [AGE_W-1:0]  ref_age, oldest;
  logic [WAYS-1:0]   new_val;
  logic [AGE_W-1:0]  new_age [WAYS];

  assign clearing  = (state == BK_CLEAR);
  assign req_ready = (state == BK_IDLE) && !out_full;
  assign res_valid = out_full;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: if (clr_cnt == (SET_W + 1)'(SETS - 1)) state_next = BK_IDLE;
      BK_IDLE:  if (req_valid && req_ready) state_next = BK_READ;
      BK_READ:  state_next = BK_WRITE;
      BK_WRITE: state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_CLEAR;
    else     state <= state_next;
  end

  // Decision on the registered row.
  always_comb begin
    nways = (ways_in_use == '0) ? WC_W'(1)
          : ({{(32 - NW_W){1'b0}}, ways_in_use} > WAYS) ? WC_W'(WAYS)
          : WC_W'(ways_in_use);
    hit = 1'b0;
    chosen = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (WC_W'(w) < nways && rd_val[w] && rd_tags[w] == cur_tag) begin
        hit = 1'b1;
        chosen = WAY_W'(w);
      end
    end
    found_empty = 1'b0;
    if (!hit) begin
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (WC_W'(w) < nways && !rd_val[w]) begin
          found_empty = 1'b1;
          chosen = WAY_W'(w);
        end
      end
      if (!found_empty) begin
        oldest = rd_age[0];
        chosen = '0;
        for (int w = 1; w < WAYS; w++) begin
          if (WC_W'(w) < nways && rd_age[w] > oldest) begin
            oldest = rd_age[w];
            chosen = WAY_W'(w);
          end
        end
      end
    end
    oldest  = rd_age[0];
    ref_age = rd_age[chosen];
    new_val = rd_val;
    for (int w = 0; w < WAYS; w++) begin
      new_age[w] = rd_age[w];
      if (WAY_W'(w) != chosen && WC_W'(w) < nways && rd_val[w]
          && (found_empty || rd_age[w] < ref_age) && rd_age[w] < AGE_MAX)
        new_age[w] = rd_age[w] + AGE_W'(1);
    end
    new_age[chosen] = '0;
    if (!hit) new_val[chosen] = 1'b1;
  end

  // Memories: read on accept, write back in the cycle after.
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && req_valid && req_ready) begin
      rd_tags <= tag_mem[req_set];
      rd_val  <= val_mem[req_set];
      rd_age  <= age_mem[req_set];
      cur_set <= req_set;
      cur_tag <= req_tag;
    end
    if (state == BK_CLEAR) begin
      val_mem[clr_cnt[SET_W-1:0]] <= '0;
      for (int w = 0; w < WAYS; w++) age_mem[clr_cnt[SET_W-1:0]][w] <= '0;
    end else if (state == BK_READ) begin
      val_mem[cur_set] <= new_val;
      age_mem[cur_set] <= new_age;
      if (!hit) tag_mem[cur_set][chosen] <= cur_tag;
    end
  end

  // Counters, clear pass and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt     <= '0;
      hits_seen   <= '0;
      misses_seen <= '0;
      out_full    <= 1'b0;
    end else begin
      if (state == BK_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (res_valid && res_ready) out_full <= 1'b0;
      if (state == BK_READ) begin
        out_full <= 1'b1;
        if (hit && hits_seen != '1) hits_seen <= hits_seen + 1'b1;
        if (!hit && misses_seen != '1) misses_seen <= misses_seen + 1'b1;
        res_data <= {3'b0,
                     (hit || misses_seen == '1) ? misses_seen : misses_seen + 1'b1,
                     (!hit || hits_seen == '1) ? hits_seen : hits_seen + 1'b1,
                     !hit && found_empty, 3'(chosen), hit};
      end
    end
  end
endmodule

### design/set_assoc_lru_cache_lookup_core.sv
`timescale 1ns / 1ps
// Set-associative cache lookup with true LRU replacement. One address per
// request; a result (hit, way, filled_empty, hit and miss counts) follows.
// The front splits each address into set and tag and queues it. The back
// reads the set's tags, valid bits and ages on the accepting edge and decides
// in the next cycle. At the end of that cycle it writes the row back and loads
// the result register. It then passes through the BK_WRITE state before it
// returns to idle and takes no new request before then. A result that the sink
// holds back stalls the next request until it is taken. After reset a clearing
// pass over every set resets valid bits and ages; no request is taken meanwhile.
module set_assoc_lru_cache_lookup_core
  import salc_pkg::*;
#(
  parameter int WAYS = WAYS_DEF,
  parameter int SETS = SETS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ADDR_W-1:0]     s_axis_tdata, // address
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata  // hit, way[3], filled_empty, hit_count, miss_count
);
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int Q_W = SET_W + ADDR_W;

  logic [OFS_W-1:0]  offset_bits;
  logic [IDXB_W-1:0] index_bits;
  logic [NW_W-1:0]   ways_in_use;
  logic [SET_W-1:0]  f_set, q_set;
  logic [ADDR_W-1:0] f_tag, q_tag;
  logic              q_in_ready, q_valid, q_ready, clearing;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFS_W'(4);
      index_bits  <= IDXB_W'(6);
      ways_in_use <= NW_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_BITS: offset_bits <= cfg_data;
        REG_INDEX_BITS:  index_bits  <= cfg_data[IDXB_W-1:0];
        REG_WAYS_IN_USE: ways_in_use <= cfg_data[NW_W-1:0];
        default: ;
      endcase
    end
  end

  salc_front #(.SETS(SETS)) u_front (
    .address(s_axis_tdata), .offset_bits(offset_bits), .index_bits(index_bits),
    .set_idx(f_set), .tag(f_tag)
  );

  assign s_axis_tready = q_in_ready && !clearing;

  salc_queue #(.W(Q_W)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid && !clearing), .in_ready(q_in_ready),
    .in_data({f_set, f_tag}),
    .out_valid(q_valid), .out_ready(q_ready), .out_data({q_set, q_tag})
  );

  salc_back #(.WAYS(WAYS), .SETS(SETS)) u_back (
    .clk(clk), .rst(rst),
    .req_valid(q_valid), .req_ready(q_ready), .req_set(q_set), .req_tag(q_tag),
    .ways_in_use(ways_in_use),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(m_axis_tdata),
    .clearing(clearing)
  );

  // No request is taken during the clearing pass.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready) else $error("request taken while clearing");
  // A hit never reports a filled empty way.
  a_hit_not_fill: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[4])) else $error("hit with fill");
endmodule

### bench/set_assoc_lru_cache_lookup_core_tb.sv
`timescale 1ns / 1ps
module set_assoc_lru_cache_lookup_core_tb;
  import salc_pkg::*;

  localparam int NWAYS = 8;
  localparam int NSETS = 1024;
  localparam int STALL_LIMIT = 20000;

  // Packed from the top bit down, so hit lands in bit 0.
  typedef struct packed {
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] hits;
    logic            filled;
    logic [2:0]      way;
    logic            hit;
  } lookup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = REG_OFFSET_BITS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ADDR_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  set_assoc_lru_cache_lookup_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the cache contents and the register settings.
  logic [31:0] shadow_tag [NSETS][NWAYS];
  logic        shadow_valid [NSETS][NWAYS];
  logic [2:0]  shadow_age [NSETS][NWAYS];
  logic [31:0] hits_total = '0;
  logic [31:0] misses_total = '0;
  logic [4:0]  offset_bits = 5'd4;
  logic [3:0]  index_bits = 4'd6;
  logic [3:0]  ways_reg = 4'd2;

  logic [ADDR_W-1:0] address_q [$];
  lookup_t expected_lookups [$];
  bit hold_sender = 0;
  bit no_idle = 0;
  bit failed = 0;

  initial begin
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) begin
        shadow_tag[s][w] = '0;
        shadow_valid[s][w] = 1'b0;
        shadow_age[s][w] = '0;
      end
    end
  end

  // Move the chosen way to the front of the LRU order.
  task automatic touch_way(int set, int nw, int chosen, bit on_hit);
    logic [2:0] ref_age;
    ref_age = shadow_age[set][chosen];
    for (int w = 0; w < nw; w++) begin
      if (w != chosen && shadow_valid[set][w] &&
          !(on_hit && shadow_age[set][w] >= ref_age) && shadow_age[set][w] != AGE_MAX)
        shadow_age[set][w] = shadow_age[set][w] + 3'd1;
    end
    shadow_age[set][chosen] = '0;
  endtask

  task automatic predict_lookup(logic [31:0] addr);
    int nw;
    int set;
    int chosen;
    int split;
    logic [63:0] shifted;
    logic [31:0] tag;
    logic [2:0] oldest;
    bit hit;
    bit empty;
    lookup_t r;
    nw = ways_reg < 1 ? 1 : (ways_reg > NWAYS ? NWAYS : ways_reg);
    shifted = {32'd0, addr} >> offset_bits;
    set = int'((shifted & ((64'd1 << index_bits) - 64'd1)) % NSETS);
    split = offset_bits + index_bits;
    tag = split >= 32 ? 32'd0 : addr >> split;
    hit = 0;
    empty = 0;
    chosen = 0;
    for (int w = 0; w < nw; w++) begin
      if (!hit && shadow_valid[set][w] && shadow_tag[set][w] == tag) begin
        hit = 1;
        chosen = w;
      end
    end
    if (hit) begin
      touch_way(set, nw, chosen, 1);
      if (hits_total != 32'hFFFF_FFFF) hits_total = hits_total + 1;
    end else begin
      for (int w = 0; w < nw; w++) begin
        if (!empty && !shadow_valid[set][w]) begin
          empty = 1;
          chosen = w;
        end
      end
      if (!empty) begin
        // Evict the oldest way, lowest number on ties.
        oldest = shadow_age[set][0];
        for (int w = 1; w < nw; w++) begin
          if (shadow_age[set][w] > oldest) begin
            oldest = shadow_age[set][w];
            chosen = w;
          end
        end
        touch_way(set, nw, chosen, 1);
      end else begin
        touch_way(set, nw, chosen, 0);
      end
      shadow_tag[set][chosen] = tag;
      shadow_valid[set][chosen] = 1'b1;
      if (misses_total != 32'hFFFF_FFFF) misses_total = misses_total + 1;
    end
    r.hit = hit;
    r.way = 3'(chosen);
    r.filled = !hit && empty;
    r.hits = hits_total;
    r.misses = misses_total;
    expected_lookups.push_back(r);
  endtask

  // Request driver.
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_lookup(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (address_q.size() > 0 && !hold_sender) begin
          if (!no_idle && $urandom_range(0, 9) == 0) begin
            src_gap = $urandom_range(0, 12);
            s_axis_tvalid <= 1'b0;
          end else begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= address_q.pop_front();
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  int sink_gap = 0;
  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = lookup_t'(m_axis_tdata[68:0]);
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          failed = 1;
        end else begin
          want = expected_lookups.pop_front();
          if (got.hit !== want.hit)
            $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
          if (got.way !== want.way)
            $display("%0t: way expected %0d actual %0d", $time, want.way, got.way);
          if (got.filled !== want.filled)
            $display("%0t: filled_empty expected %0d actual %0d", $time, want.filled,
                     got.filled);
          if (got.hits !== want.hits)
            $display("%0t: hit_count expected %0d actual %0d", $time, want.hits, got.hits);
          if (got.misses !== want.misses)
            $display("%0t: miss_count expected %0d actual %0d", $time, want.misses,
                     got.misses);
          if (got !== want) failed = 1;
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (address_q.size() > 0 || s_axis_tvalid || expected_lookups.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Holds the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_OFFSET_BITS: offset_bits = val;
      REG_INDEX_BITS: index_bits = val[3:0];
      default: ways_reg = val[3:0];
    endcase
  endtask

  task automatic configure(int ofs, int ib, int nw);
    wait_drained();
    write_reg(REG_OFFSET_BITS, 5'(ofs));
    write_reg(REG_INDEX_BITS, 5'(ib));
    write_reg(REG_WAYS_IN_USE, 5'(nw));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Address built from a tag and a set under the current split.
  function automatic logic [31:0] make_address(int tag, int set);
    logic [63:0] a;
    int split;
    split = offset_bits + index_bits;
    a = {32'd0, $urandom} & ((64'd1 << offset_bits) - 64'd1);
    a = a | ((64'(set) & ((64'd1 << index_bits) - 64'd1)) << offset_bits);
    if (split < 32) a = a | (64'(tag) << split);
    return a[31:0];
  endfunction

  // Mostly reuse a few tags over a few sets so hits and evictions happen.
  task automatic queue_random(int n);
    int nw;
    for (int i = 0; i < n; i++) begin
      nw = ways_reg < 1 ? 1 : ways_reg;
      if ($urandom_range(0, 9) == 0)
        address_q.push_back($urandom);
      else
        address_q.push_back(make_address($urandom_range(0, nw + 2), $urandom_range(0, 3)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);

    // Directed: extremes, filling a set, hits and an eviction.
    configure(4, 6, 2);
    address_q.push_back(32'h0000_0000);
    address_q.push_back(32'hFFFF_FFFF);
    address_q.push_back(32'h0000_0000);
    address_q.push_back(32'h0000_0400);
    address_q.push_back(32'h0000_0800);
    address_q.push_back(32'h0000_0400);
    address_q.push_back(32'h0000_000F);
    address_q.push_back(32'h0000_0C00);
    address_q.push_back(32'hFFFF_FFF0);
    address_q.push_back(32'h8000_0000);
    // Ways zero and above the limit, index folding, wide split.
    configure(0, 15, 0);
    for (int i = 0; i < 4; i++) address_q.push_back(make_address(i & 1, 1));
    configure(22, 10, 15);
    for (int i = 0; i < 10; i++) address_q.push_back(make_address(0, i % 3));
    configure(31, 1, 8);
    address_q.push_back(32'h8000_0000);
    address_q.push_back(32'h7FFF_FFFF);

    // Random phases under several splits.
    configure(0, 0, 1);
    queue_random(100);
    configure(4, 6, 2);
    queue_random(60);
    wait (address_q.size() < 30);
    hold_sender = 1;
    while (s_axis_tvalid || expected_lookups.size() > 0) @(posedge clk);
    hold_sender = 0;
    configure(0, 10, 8);
    queue_random(150);
    configure(20, 10, 4);
    queue_random(100);
    configure(31, 1, 8);
    queue_random(80);
    configure(3, 12, 15);
    queue_random(120);
    configure(2, 3, 5);
    queue_random(150);
    configure(6, 2, 3);
    queue_random(120);
    configure(4, 6, 8);
    no_idle = 1;
    queue_random(120);
    wait_drained();
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

### sim.f
design/salc_pkg.sv
design/salc_front.sv
design/salc_queue.sv
design/salc_back.sv
design/set_assoc_lru_cache_lookup_core.sv
bench/set_assoc_lru_cache_lookup_core_tb.sv
